// ----- design/ring_fifo_filtered_dequeue_assert.svh -----
// Assertion macros for the filtered-dequeue ring FIFO.
`ifndef RING_FIFO_FILTERED_DEQUEUE_ASSERT_SVH
`define RING_FIFO_FILTERED_DEQUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RFFD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rffd assertion failed");

// Next-cycle implication, disabled while reset is high.
`define RFFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rffd assertion failed");

`endif

// ----- design/rffd_pkg.sv -----
package rffd_pkg;

   localparam int DEPTH = 16;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam int FIELD_W = 32;
   localparam int SUM_W   = FIELD_W + 1;
   localparam int DISC_W  = 4;
   localparam int STAT_W  = 3;

   typedef logic [PTR_W-1:0] ptr_type;

   localparam logic FUNC_ENQ = 1'b0;
   localparam logic FUNC_DEQ = 1'b1;

   localparam logic [STAT_W-1:0] ST_ENQUEUED  = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STAT_W-1:0] ST_MATCH     = 3'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STAT_W-1:0] ST_EXHAUSTED = 3'd4;

   localparam logic [DISC_W-1:0] DISCARD_MAX = 4'd15;

   localparam logic signed [SUM_W-1:0] THRESHOLD_RESET = 33'sd8;

   typedef struct packed {
      logic                      func;
      logic signed [FIELD_W-1:0] first_value;
      logic signed [FIELD_W-1:0] second_value;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]         status;
      logic signed [FIELD_W-1:0] out_first;
      logic signed [FIELD_W-1:0] out_second;
      logic [DISC_W-1:0]         discarded;
   } rsp_type;

   // second in the upper half, first in the lower half
   typedef struct packed {
      logic signed [FIELD_W-1:0] second;
      logic signed [FIELD_W-1:0] first;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   function automatic ptr_type next_slot(input ptr_type p);
      ptr_type r;
      if (p == ptr_type'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + ptr_type'(1);
      end
      return r;
   endfunction

endpackage

// ----- design/ring_fifo_filtered_dequeue.sv -----
// Enqueue, full, and empty-queue requests: result registered and shown the cycle after accept, busy stays low.
// Dequeue of a non-empty queue: one popped entry per cycle through the
// add/compare unit, result registered and shown the cycle after the last pop.
// Each result strobes rsp_valid for one cycle; the receiver cannot stall.
// Synchronous reset: queue empty, pointers zero, threshold 8, no result pending.
// Entry storage is not cleared; slots are only read after being written.
module ring_fifo_filtered_dequeue (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  rffd_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   output rffd_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_wr_en,
   input  logic signed [rffd_pkg::SUM_W-1:0]      csr_wr_data
);

`include "ring_fifo_filtered_dequeue_assert.svh"

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic                                state_ff, state_in;
   rffd_pkg::ptr_type                   rp_ff, rp_in;
   rffd_pkg::ptr_type                   wp_ff, wp_in;
   logic                                empty_ff, empty_in;
   logic [rffd_pkg::DISC_W-1:0]         drop_ff, drop_in;
   logic signed [rffd_pkg::SUM_W-1:0]   thr_ff, thr_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   rffd_pkg::rsp_type                   rsp_data_ff, rsp_data_in;

   logic                                wr_en;
   rffd_pkg::entry_type                 wr_entry;
   rffd_pkg::entry_type                 rd_entry;
   logic [rffd_pkg::ENTRY_W-1:0]        rd_word;
   logic                                meets;
   logic                                full;
   rffd_pkg::ptr_type                   rp_next;
   logic [rffd_pkg::DISC_W-1:0]         drop_sat;

   assign wr_entry.first  = req_data.first_value;
   assign wr_entry.second = req_data.second_value;
   assign rd_entry        = rffd_pkg::entry_type'(rd_word);

   // read address follows the next head so data lines up with rp_ff
   rffd_ram #(
      .ADDR_W (rffd_pkg::PTR_W),
      .DATA_W (rffd_pkg::ENTRY_W),
      .WORDS  (rffd_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_entry),
      .rd_addr (rp_in),
      .rd_data (rd_word)
   );

   rffd_sum_cmp u_cmp (
      .entry     (rd_entry),
      .threshold (thr_ff),
      .meets     (meets)
   );

   assign full     = !empty_ff && (rffd_pkg::next_slot(wp_ff) == rp_ff);
   assign rp_next  = rffd_pkg::next_slot(rp_ff);
   assign drop_sat = (drop_ff == rffd_pkg::DISCARD_MAX) ? drop_ff
                                                         : drop_ff + 1'b1;
   assign thr_in   = csr_wr_en ? csr_wr_data : thr_ff;

   always_comb begin
      state_in     = state_ff;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      empty_in     = empty_ff;
      drop_in      = drop_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      wr_en        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_valid_in = 1'b1;
               if (req_data.func == rffd_pkg::FUNC_ENQ) begin
                  if (full) begin
                     rsp_data_in.status = rffd_pkg::ST_FULL;
                  end else begin
                     wr_en              = 1'b1;
                     wp_in              = rffd_pkg::next_slot(wp_ff);
                     empty_in           = 1'b0;
                     rsp_data_in.status = rffd_pkg::ST_ENQUEUED;
                  end
               end else if (empty_ff) begin
                  rsp_data_in.status = rffd_pkg::ST_EMPTY;
               end else begin
                  rsp_valid_in = 1'b0;
                  drop_in      = '0;
                  state_in     = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            rp_in = rp_next;
            if (rp_next == wp_ff) begin
               empty_in = 1'b1;
            end
            if (meets) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.status     = rffd_pkg::ST_MATCH;
               rsp_data_in.out_first  = rd_entry.first;
               rsp_data_in.out_second = rd_entry.second;
               rsp_data_in.discarded  = drop_ff;
               state_in               = S_IDLE;
            end else begin
               drop_in = drop_sat;
               if (rp_next == wp_ff) begin
                  rsp_valid_in          = 1'b1;
                  rsp_data_in.status    = rffd_pkg::ST_EXHAUSTED;
                  rsp_data_in.discarded = drop_sat;
                  state_in              = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rp_ff        <= '0;
         wp_ff        <= '0;
         empty_ff     <= 1'b1;
         drop_ff      <= '0;
         thr_ff       <= rffd_pkg::THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         empty_ff     <= empty_in;
         drop_ff      <= drop_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff == S_SCAN);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // every accepted request either answers next cycle or starts a scan
   `RFFD_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, rsp_valid || busy)

   // a scan only runs over a non-empty queue
   `RFFD_ASSERT_NOW(a_scan_nonempty, clock, reset, busy, !empty_ff)

   // returned fields are zero unless an entry matched
   `RFFD_ASSERT_NOW(a_fields_zero, clock, reset,
      rsp_valid && (rsp_data.status != rffd_pkg::ST_MATCH),
      (rsp_data.out_first == '0) && (rsp_data.out_second == '0))

endmodule

// ----- design/rffd_ram.sv -----
module rffd_ram #(
   parameter int ADDR_W = 4,
   parameter int DATA_W = 64,
   parameter int WORDS  = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [WORDS];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/rffd_sum_cmp.sv -----
module rffd_sum_cmp (
   input  rffd_pkg::entry_type                     entry,
   input  logic signed [rffd_pkg::SUM_W-1:0]       threshold,
   output logic                                    meets
);

   logic signed [rffd_pkg::SUM_W-1:0] sum;

   // exact 33-bit sum, no overflow possible
   assign sum = {entry.first[rffd_pkg::FIELD_W-1], entry.first}
              + {entry.second[rffd_pkg::FIELD_W-1], entry.second};

   assign meets = (sum >= threshold);

endmodule

// ----- verif/ring_fifo_filtered_dequeue_check.sv -----
module ring_fifo_filtered_dequeue_check
   import rffd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  req_type                  req_data,
   input  logic                     rsp_valid,
   input  rsp_type                  rsp_data,
   input  logic                     csr_wr_en,
   input  logic signed [SUM_W-1:0]  csr_wr_data,
   output int                       failures,
   output int                       pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RSP_W = $bits(rsp_type);

   entry_type                slots [DEPTH];
   ptr_type                  head;
   ptr_type                  tail;
   logic                     drained;
   logic signed [SUM_W-1:0]  threshold;

   rsp_type                  predicted_rsp [$];
   rsp_type                  want_rsp;
   int                       mismatch_total = 0;

   function automatic ptr_type step_slot(input ptr_type p);
      return ptr_type'((int'(p) + 1) % DEPTH);
   endfunction

   // Applies one request to the local queue copy and returns its result.
   function automatic rsp_type serve_request(input req_type r);
      rsp_type                  res;
      entry_type                e;
      logic signed [SUM_W-1:0]  total;
      logic                     done;
      res  = '0;
      done = 1'b0;
      if (r.func == FUNC_ENQ) begin
         if (!drained && step_slot(tail) == head) begin
            res.status = ST_FULL;
         end else begin
            slots[tail] = {r.second_value, r.first_value};
            tail        = step_slot(tail);
            drained     = 1'b0;
            res.status  = ST_ENQUEUED;
         end
      end else if (drained) begin
         res.status = ST_EMPTY;
      end else begin
         res.status = ST_EXHAUSTED;
         while (!done) begin
            e     = slots[head];
            // exact 33-bit sum, no wrap possible
            total = {e.first[FIELD_W-1], e.first} + {e.second[FIELD_W-1], e.second};
            head  = step_slot(head);
            if (head == tail) begin
               drained = 1'b1;
            end
            if (total >= threshold) begin
               res.status     = ST_MATCH;
               res.out_first  = e.first;
               res.out_second = e.second;
               done           = 1'b1;
            end else begin
               if (res.discarded != DISCARD_MAX) begin
                  res.discarded = res.discarded + 1'b1;
               end
               if (drained) begin
                  done = 1'b1;
               end
            end
         end
      end
      return res;
   endfunction

   task automatic report(input string what, input logic [RSP_W-1:0] got,
                         input logic [RSP_W-1:0] want);
      $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatch_total++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         head      = '0;
         tail      = '0;
         drained   = 1'b1;
         threshold = THRESHOLD_RESET;
         predicted_rsp.delete();
      end else begin
         if (rsp_valid) begin
            if (predicted_rsp.size() == 0) begin
               report("unexpected result", rsp_data, '0);
            end else begin
               want_rsp = predicted_rsp.pop_front();
               if (rsp_data.status !== want_rsp.status) begin
                  report("status", rsp_data.status, want_rsp.status);
               end
               if (rsp_data.out_first !== want_rsp.out_first) begin
                  report("out_first", rsp_data.out_first, want_rsp.out_first);
               end
               if (rsp_data.out_second !== want_rsp.out_second) begin
                  report("out_second", rsp_data.out_second, want_rsp.out_second);
               end
               if (rsp_data.discarded !== want_rsp.discarded) begin
                  report("discarded", rsp_data.discarded, want_rsp.discarded);
               end
            end
         end
         if (csr_wr_en) begin
            threshold = csr_wr_data;
         end
         if (start && !busy) begin
            predicted_rsp.push_back(serve_request(req_data));
         end
      end
      pending_count <= predicted_rsp.size();
      failures      <= mismatch_total;
   end

endmodule

// ----- verif/ring_fifo_filtered_dequeue_test.sv -----
module ring_fifo_filtered_dequeue_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rffd_pkg::*;

   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 102;
   localparam int WATCHDOG_LIMIT  = 1000;

   localparam logic signed [FIELD_W-1:0] FIELD_MIN = 32'sh8000_0000;
   localparam logic signed [FIELD_W-1:0] FIELD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [SUM_W-1:0]   THR_MIN   = 33'sh1_0000_0000;
   localparam logic signed [SUM_W-1:0]   THR_MAX   = 33'sh0_FFFF_FFFE;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     start       = 1'b0;
   req_type                  req_data    = '0;
   logic                     csr_wr_en   = 1'b0;
   logic signed [SUM_W-1:0]  csr_wr_data = '0;
   logic                     busy;
   logic                     rsp_valid;
   rsp_type                  rsp_data;
   int                       failures;
   int                       pending_count;
   logic signed [SUM_W-1:0]  thr_now     = THRESHOLD_RESET;

   ring_fifo_filtered_dequeue DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ring_fifo_filtered_dequeue_check fifo_check (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .failures      (failures),
      .pending_count (pending_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("TEST FAILED");
      $finish;
   end

   // start is left high after the accept so back-to-back requests never toggle it
   task automatic send_request(input logic f, input logic signed [FIELD_W-1:0] a,
                               input logic signed [FIELD_W-1:0] b, input int gap);
      req_type r;
      r.func         = f;
      r.first_value  = a;
      r.second_value = b;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 || busy) @(posedge clock);
   endtask

   task automatic write_threshold(input logic signed [SUM_W-1:0] v);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      thr_now      = v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic int draw_gap(input int style);
      int g;
      case (style)
         0: g = 0;
         1: g = $urandom_range(0, 19);
         default: g = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 19);
      endcase
      return g;
   endfunction

   // mix of full-range, corner, small and near-threshold values
   function automatic logic signed [FIELD_W-1:0] pick_value();
      logic signed [FIELD_W-1:0] v;
      int                        sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1, 2, 3: v = $urandom();
         4, 5: begin
            case ($urandom_range(0, 3))
               0: v = FIELD_MIN;
               1: v = FIELD_MAX;
               2: v = '0;
               default: v = -1;
            endcase
         end
         6, 7: v = $urandom_range(0, 32) - 16;
         default: v = thr_now[SUM_W-1:1] + ($urandom_range(0, 6) - 3);
      endcase
      return v;
   endfunction

   function automatic logic signed [SUM_W-1:0] phase_threshold(input int phase);
      logic signed [SUM_W-1:0] t;
      int                      small_thr;
      case (phase)
         0, 9: t = THR_MIN;
         1, 8: t = THR_MAX;
         2, 7: begin
            small_thr = $urandom_range(0, 80);
            t = small_thr - 40;
         end
         4: t = THRESHOLD_RESET;
         5: t = '0;
         default: begin
            t = {1'($urandom_range(0, 1)), 32'($urandom())};
            if (t == 33'sh0_FFFF_FFFF) begin
               t = THR_MAX;
            end
         end
      endcase
      return t;
   endfunction

   initial begin
      int enq_pct;
      logic f;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset threshold of 8 still in force here
      send_request(FUNC_DEQ, '0, '0, draw_gap(2));
      send_request(FUNC_ENQ, 32'sd7, 32'sd0, draw_gap(2));
      send_request(FUNC_ENQ, FIELD_MIN, FIELD_MIN, draw_gap(2));
      send_request(FUNC_ENQ, 32'sd8, 32'sd0, draw_gap(2));
      send_request(FUNC_ENQ, FIELD_MAX, FIELD_MAX, draw_gap(2));
      send_request(FUNC_ENQ, FIELD_MIN, FIELD_MAX, draw_gap(2));
      send_request(FUNC_DEQ, FIELD_MAX, FIELD_MAX, draw_gap(2));
      send_request(FUNC_DEQ, '0, '0, draw_gap(2));
      send_request(FUNC_DEQ, '0, '0, draw_gap(2));
      send_request(FUNC_DEQ, FIELD_MIN, FIELD_MIN, draw_gap(2));
      // fill to capacity with sums just under threshold, overflow, then drop all
      for (int k = 0; k < DEPTH - 1; k++) begin
         send_request(FUNC_ENQ, k, 7 - k, draw_gap(2));
      end
      send_request(FUNC_ENQ, FIELD_MAX, FIELD_MAX, draw_gap(2));
      send_request(FUNC_DEQ, '0, '0, draw_gap(2));

      for (int phase = 0; phase < PHASES; phase++) begin
         write_threshold(phase_threshold(phase));
         enq_pct = (phase % 2 == 0) ? 65 : 45;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            f = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
            send_request(f, pick_value(), pick_value(), draw_gap(phase % 3));
         end
      end

      settle();
      repeat (DEPTH + 4) @(posedge clock);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+design
design/rffd_pkg.sv
design/rffd_ram.sv
design/rffd_sum_cmp.sv
design/ring_fifo_filtered_dequeue.sv
verif/ring_fifo_filtered_dequeue_check.sv
verif/ring_fifo_filtered_dequeue_test.sv
